@@ hw/rtl/bco_pkg.sv @@
package bco_pkg;

  localparam int ANGLE_FRAC_BITS   = 13;
  localparam int CORDIC_STEPS      = 16;
  localparam int MAX_BLOCK_SIDE    = 256;
  localparam int MAX_BLOCKS_ACROSS = 64;

  localparam int TAB_FRAC  = 30;
  localparam int TAB_LEN   = 24;
  localparam int RUN_STEPS = (CORDIC_STEPS > TAB_LEN) ? TAB_LEN : CORDIC_STEPS;
  localparam int SIDE_MAX  = (MAX_BLOCK_SIDE > 256) ? 256 : MAX_BLOCK_SIDE;
  localparam int ACROSS_MAX = (MAX_BLOCKS_ACROSS > 64) ? 64 : MAX_BLOCKS_ACROSS;
  localparam int FW_MAX    = 16384;
  localparam int ROUND_SH  = TAB_FRAC - ANGLE_FRAC_BITS;

  localparam int ACC_W   = 24;
  localparam int CNT_W   = 17;
  localparam int RAM_DEPTH = 64;
  localparam int CFG_DATA_W = 17;
  localparam int CFG_IDX_W  = 4;

  localparam longint ATAN_TAB [0:TAB_LEN-1] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128
  };
  localparam longint HALF_PI_TAB = 1686629713;
  localparam longint ANGLE_LIM_L =
    (HALF_PI_TAB + (longint'(1) << (ROUND_SH - 1))) >>> ROUND_SH;
  localparam logic signed [15:0] ANGLE_LIM = 16'(ANGLE_LIM_L);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD     = 4'd0,
    REG_FRAME_WIDTH   = 4'd1,
    REG_BLOCK_WIDTH   = 4'd2,
    REG_BLOCK_HEIGHT  = 4'd3,
    REG_BLOCKS_ACROSS = 4'd4,
    REG_BLOCKS_DOWN   = 4'd5,
    REG_LOWER_COUNT   = 4'd6,
    REG_UPPER_COUNT   = 4'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    B_IDLE, B_PREP, B_MUL, B_DIFF, B_SIGN, B_NORM, B_ROT, B_OUT
  } back_state_t;

  // sizes already limited to their legal ranges
  typedef struct packed {
    logic [7:0]  threshold;
    logic [14:0] fw;
    logic [8:0]  bw;
    logic [8:0]  bh;
    logic [6:0]  ba;
    logic [6:0]  bd;
    logic [16:0] lower;
    logic [16:0] upper;
  } cfg_t;

  typedef struct packed {
    logic [ACC_W-1:0] wr;
    logic [ACC_W-1:0] wc;
    logic [ACC_W-1:0] br;
    logic [ACC_W-1:0] bc;
    logic [CNT_W-1:0] nw;
  } acc_t;

  typedef struct packed {
    logic [5:0] brow;
    logic [5:0] bcol;
    logic       last;
    acc_t       acc;
  } blk_t;

  function automatic logic signed [15:0] atan_z(input logic [4:0] i);
    longint t;
    t = (ATAN_TAB[i] + (longint'(1) << (ROUND_SH - 1))) >>> ROUND_SH;
    return 16'(t);
  endfunction

endpackage

@@ hw/rtl/bco_if.sv @@
interface bco_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;
  logic       start_of_frame;
  modport source(output valid, pixel, start_of_frame, input ready);
  modport sink(input valid, pixel, start_of_frame, output ready);
endinterface

interface bco_res_if;
  logic               valid;
  logic               ready;
  logic [5:0]         block_row;
  logic [5:0]         block_col;
  logic signed [14:0] angle;
  logic               blend_ok;
  logic               last_of_frame;
  modport source(output valid, block_row, block_col, angle, blend_ok, last_of_frame,
                 input ready);
  modport sink(input valid, block_row, block_col, angle, blend_ok, last_of_frame,
               output ready);
endinterface

interface bco_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [16:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

@@ hw/rtl/bco_ram.sv @@
module bco_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

@@ hw/rtl/bco_front.sv @@
module bco_front (
  input  logic          clk,
  input  logic          rst,
  bco_pix_if.sink       pix,
  input  bco_pkg::cfg_t cfg,
  input  logic          room,
  output logic          push,
  output bco_pkg::blk_t blk
);
  import bco_pkg::*;

  logic [13:0] line_position;
  logic [7:0]  col_in_block, row_in_block;
  logic [5:0]  cur_col, cur_row;
  logic        past_cols, past_grid;

  logic [13:0] lp;
  logic [7:0]  cib, rib;
  logic [5:0]  ccol, crow;
  logic        pc, pg;
  logic        accept, active;

  logic [13:0] lp_next;
  logic [7:0]  cib_next, rib_next;
  logic [5:0]  ccol_next, crow_next;
  logic        pc_next, pg_next;

  logic        s1_valid, s1_white, s1_clear, s1_finish, s1_last, s1_fwd;
  logic [5:0]  s1_addr, s1_brow;
  logic [7:0]  s1_row, s1_col;
  acc_t        acc_last, acc_base, acc_new;
  logic [$bits(acc_t)-1:0] rdata;

  assign accept    = pix.valid && room;
  assign pix.ready = room;

  // start of frame clears the position before the pixel is used
  always_comb begin
    lp   = pix.start_of_frame ? '0 : line_position;
    cib  = pix.start_of_frame ? '0 : col_in_block;
    rib  = pix.start_of_frame ? '0 : row_in_block;
    ccol = pix.start_of_frame ? '0 : cur_col;
    crow = pix.start_of_frame ? '0 : cur_row;
    pc   = pix.start_of_frame ? 1'b0 : past_cols;
    pg   = pix.start_of_frame ? 1'b0 : past_grid;
    active = !pg && !pc && ({1'b0, ccol} < cfg.ba) && ({1'b0, crow} < cfg.bd);

    lp_next = lp; cib_next = cib; rib_next = rib;
    ccol_next = ccol; crow_next = crow; pc_next = pc; pg_next = pg;
    if ({1'b0, lp} + 15'd1 >= cfg.fw) begin
      lp_next = '0; cib_next = '0; ccol_next = '0; pc_next = 1'b0;
      if ({1'b0, rib} + 9'd1 >= cfg.bh) begin
        rib_next = '0;
        if ({1'b0, crow} + 7'd1 >= cfg.bd) begin
          crow_next = '0;
          pg_next   = 1'b1;
        end else begin
          crow_next = crow + 6'd1;
        end
      end else begin
        rib_next = rib + 8'd1;
      end
    end else begin
      lp_next = lp + 14'd1;
      if ({1'b0, cib} + 9'd1 >= cfg.bw) begin
        cib_next = '0;
        if ({1'b0, ccol} + 7'd1 >= cfg.ba) begin
          ccol_next = '0;
          pc_next   = 1'b1;
        end else begin
          ccol_next = ccol + 6'd1;
        end
      end else begin
        cib_next = cib + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_position <= '0;
      col_in_block  <= '0;
      row_in_block  <= '0;
      cur_col       <= '0;
      cur_row       <= '0;
      past_cols     <= 1'b0;
      past_grid     <= 1'b0;
      s1_valid      <= 1'b0;
    end else begin
      s1_valid <= accept && active;
      if (accept) begin
        line_position <= lp_next;
        col_in_block  <= cib_next;
        row_in_block  <= rib_next;
        cur_col       <= ccol_next;
        cur_row       <= crow_next;
        past_cols     <= pc_next;
        past_grid     <= pg_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr   <= ccol;
      s1_brow   <= crow;
      s1_row    <= rib;
      s1_col    <= cib;
      s1_white  <= pix.pixel > cfg.threshold;
      s1_clear  <= (rib == '0) && (cib == '0);
      s1_finish <= ({1'b0, cib} + 9'd1 >= cfg.bw) && ({1'b0, rib} + 9'd1 >= cfg.bh);
      s1_last   <= ({1'b0, crow} + 7'd1 == cfg.bd) && ({1'b0, ccol} + 7'd1 == cfg.ba);
      // the entry written this cycle is stale in the memory read
      s1_fwd    <= s1_valid && (s1_addr == ccol);
    end
    if (s1_valid) begin
      acc_last <= acc_new;
    end
  end

  bco_ram #(
    .WIDTH($bits(acc_t)),
    .DEPTH(RAM_DEPTH)
  ) u_acc_ram (
    .clk  (clk),
    .we   (s1_valid),
    .waddr(s1_addr),
    .wdata(acc_new),
    .re   (accept && active),
    .raddr(ccol),
    .rdata(rdata)
  );

  always_comb begin
    if (s1_clear) begin
      acc_base = '0;
    end else if (s1_fwd) begin
      acc_base = acc_last;
    end else begin
      acc_base = acc_t'(rdata);
    end
    acc_new = acc_base;
    if (s1_white) begin
      acc_new.wr = acc_base.wr + {16'd0, s1_row};
      acc_new.wc = acc_base.wc + {16'd0, s1_col};
      acc_new.nw = acc_base.nw + 17'd1;
    end else begin
      acc_new.br = acc_base.br + {16'd0, s1_row};
      acc_new.bc = acc_base.bc + {16'd0, s1_col};
    end
  end

  assign push      = s1_valid && s1_finish;
  assign blk.brow  = s1_brow;
  assign blk.bcol  = s1_addr;
  assign blk.last  = s1_last;
  assign blk.acc   = acc_new;
endmodule

@@ hw/rtl/bco_queue.sv @@
module bco_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bco_pkg::blk_t push_data,
  input  logic          pop,
  output logic          head_valid,
  output bco_pkg::blk_t head,
  output logic          room
);
  import bco_pkg::*;

  localparam int PW = $clog2(DEPTH);

  blk_t           slots [DEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [PW:0]    count;
  logic           do_pop;

  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];
  assign do_pop     = pop && head_valid;
  // one beat may still be in flight in the front stage
  assign room       = count <= (PW+1)'(DEPTH - 2);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (PW+1)'(push) - (PW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count < (PW+1)'(DEPTH)) || do_pop)
    else $error("block queue overflow");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (PW+1)'(DEPTH))
    else $error("block queue count out of range");

  a_room_follows: assert property (@(posedge clk) disable iff (rst)
    !room |=> (count >= $past(count)) || $past(do_pop))
    else $error("block queue count moved without a pop");
endmodule

@@ hw/rtl/bco_back.sv @@
module bco_back (
  input  logic          clk,
  input  logic          rst,
  input  bco_pkg::cfg_t cfg,
  input  logic          q_valid,
  input  bco_pkg::blk_t q_blk,
  output logic          q_pop,
  bco_res_if.source     res
);
  import bco_pkg::*;

  back_state_t state, state_next;

  blk_t               rec;
  logic [16:0]        nb;
  logic               ok;
  logic [40:0]        p_wr, p_br, p_wc, p_bc;
  logic signed [41:0] cr, cc;
  logic signed [56:0] x, y;
  logic signed [15:0] z;
  logic [4:0]         step;

  logic [17:0]        tot;
  logic [56:0]        ymag, big;
  logic signed [56:0] xs, ys;
  logic signed [15:0] t, zsat;
  logic               out_free, last_step, skip;

  assign tot       = 18'(cfg.bw * cfg.bh);
  assign ymag      = y[56] ? 57'(-y) : 57'(y);
  assign big       = (57'(x) > ymag) ? 57'(x) : ymag;
  assign xs        = x >>> step;
  assign ys        = y >>> step;
  assign t         = atan_z(step);
  assign last_step = step == 5'(RUN_STEPS - 1);
  assign skip      = !ok || (cc == '0);
  assign out_free  = !res.valid || res.ready;

  always_comb begin
    if (z > ANGLE_LIM) begin
      zsat = ANGLE_LIM;
    end else if (z < -ANGLE_LIM) begin
      zsat = -ANGLE_LIM;
    end else begin
      zsat = z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    case (state)
      B_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = B_PREP;
        end
      end
      B_PREP: state_next = B_MUL;
      B_MUL:  state_next = B_DIFF;
      B_DIFF: state_next = B_SIGN;
      B_SIGN: state_next = skip ? B_OUT : B_NORM;
      B_NORM: begin
        if (big[56:52] != '0) begin
          state_next = B_ROT;
        end
      end
      B_ROT: begin
        if (last_step) begin
          state_next = B_OUT;
        end
      end
      B_OUT: begin
        if (out_free) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        rec <= q_blk;
      end
      B_PREP: begin
        nb <= (tot > {1'b0, rec.acc.nw}) ? 17'(tot - {1'b0, rec.acc.nw}) : '0;
        ok <= (rec.acc.nw > cfg.lower) && (rec.acc.nw < cfg.upper);
      end
      B_MUL: begin
        p_wr <= rec.acc.wr * nb;
        p_br <= rec.acc.br * rec.acc.nw;
        p_wc <= rec.acc.wc * nb;
        p_bc <= rec.acc.bc * rec.acc.nw;
      end
      B_DIFF: begin
        cr <= $signed({1'b0, p_wr}) - $signed({1'b0, p_br});
        cc <= $signed({1'b0, p_wc}) - $signed({1'b0, p_bc});
      end
      B_SIGN: begin
        z    <= '0;
        step <= '0;
        if (cc[41]) begin
          x <= -57'(cc);
          y <= -57'(cr);
        end else begin
          x <= 57'(cc);
          y <= 57'(cr);
        end
      end
      B_NORM: begin
        // coarse shift while far below the working range
        if (big[56:44] == '0) begin
          x <= x <<< 8;
          y <= y <<< 8;
        end else if (big[56:52] == '0) begin
          x <= x <<< 1;
          y <= y <<< 1;
        end
      end
      B_ROT: begin
        step <= step + 5'd1;
        if (!y[56]) begin
          x <= x + ys;
          y <= y - xs;
          z <= z + t;
        end else begin
          x <= x - ys;
          y <= y + xs;
          z <= z - t;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (state == B_OUT && out_free) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_OUT && out_free) begin
      res.block_row     <= rec.brow;
      res.block_col     <= rec.bcol;
      res.angle         <= skip ? '0 : zsat[14:0];
      res.blend_ok      <= ok;
      res.last_of_frame <= rec.last;
    end
  end
endmodule

@@ hw/rtl/block_centroid_orientation.sv @@
// pixels: one beat per cycle; the front stage takes a pixel every cycle while the
//   block queue has room, accumulators live in a 64-entry memory, read the cycle before they are updated
// block result: computed after the last pixel of the block with the back end free, through the prep,
//   multiply, difference, sign, shared normalise shifter and 16-step cordic states, one block at a time
// reset: position counters, queue and output valid clear; accumulator memory is not
//   cleared, each block clears its entry on its first pixel
module block_centroid_orientation (
  input  logic      clk,
  input  logic      rst,
  bco_pix_if.sink   pix,
  bco_res_if.source res,
  bco_cfg_if.sink   cfg
);
  import bco_pkg::*;

  logic [7:0]  threshold;
  logic [14:0] frame_width;
  logic [8:0]  block_width, block_height;
  logic [6:0]  blocks_across, blocks_down;
  logic [16:0] lower_count, upper_count;

  cfg_t  cfg_eff;
  logic  q_push, q_pop, q_valid, q_room;
  blk_t  q_in, q_head;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold     <= 8'd128;
      frame_width   <= 15'd640;
      block_width   <= 9'd16;
      block_height  <= 9'd16;
      blocks_across <= 7'd40;
      blocks_down   <= 7'd30;
      lower_count   <= 17'd0;
      upper_count   <= 17'd65536;
    end else if (cfg.valid) begin
      case (reg_idx_t'(cfg.index))
        REG_THRESHOLD:     threshold     <= cfg.data[7:0];
        REG_FRAME_WIDTH:   frame_width   <= cfg.data[14:0];
        REG_BLOCK_WIDTH:   block_width   <= cfg.data[8:0];
        REG_BLOCK_HEIGHT:  block_height  <= cfg.data[8:0];
        REG_BLOCKS_ACROSS: blocks_across <= cfg.data[6:0];
        REG_BLOCKS_DOWN:   blocks_down   <= cfg.data[6:0];
        REG_LOWER_COUNT:   lower_count   <= cfg.data;
        REG_UPPER_COUNT:   upper_count   <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  // zero reads as one, sizes limited to what the grid supports
  always_comb begin
    cfg_eff.threshold = threshold;
    cfg_eff.lower     = lower_count;
    cfg_eff.upper     = upper_count;
    if (frame_width == '0) cfg_eff.fw = 15'd1;
    else if (frame_width > 15'(FW_MAX)) cfg_eff.fw = 15'(FW_MAX);
    else cfg_eff.fw = frame_width;
    if (block_width == '0) cfg_eff.bw = 9'd1;
    else if (block_width > 9'(SIDE_MAX)) cfg_eff.bw = 9'(SIDE_MAX);
    else cfg_eff.bw = block_width;
    if (block_height == '0) cfg_eff.bh = 9'd1;
    else if (block_height > 9'(SIDE_MAX)) cfg_eff.bh = 9'(SIDE_MAX);
    else cfg_eff.bh = block_height;
    if (blocks_across == '0) cfg_eff.ba = 7'd1;
    else if (blocks_across > 7'(ACROSS_MAX)) cfg_eff.ba = 7'(ACROSS_MAX);
    else cfg_eff.ba = blocks_across;
    if (blocks_down == '0) cfg_eff.bd = 7'd1;
    else if (blocks_down > 7'd64) cfg_eff.bd = 7'd64;
    else cfg_eff.bd = blocks_down;
  end

  bco_front u_front (
    .clk (clk),
    .rst (rst),
    .pix (pix),
    .cfg (cfg_eff),
    .room(q_room),
    .push(q_push),
    .blk (q_in)
  );

  bco_queue #(
    .DEPTH(4)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head_valid(q_valid),
    .head      (q_head),
    .room      (q_room)
  );

  bco_back u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_eff),
    .q_valid(q_valid),
    .q_blk  (q_head),
    .q_pop  (q_pop),
    .res    (res)
  );
endmodule

@@ dv/block_centroid_orientation_tb.sv @@
module block_centroid_orientation_tb;
  import bco_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 60;
  localparam int ITEM_GOAL = 1300;

  typedef struct {
    logic [7:0] pixel;
    logic       sof;
  } pix_item_t;

  typedef struct {
    reg_idx_t    idx;
    logic [16:0] data;
  } reg_write_t;

  typedef struct {
    logic [5:0]  brow;
    logic [5:0]  bcol;
    logic [14:0] angle;
    logic        ok;
    logic        last;
  } orient_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bco_pix_if pix ();
  bco_res_if res ();
  bco_cfg_if cfg ();

  block_centroid_orientation i_dut (
    .clk(clk),
    .rst(rst),
    .pix(pix.sink),
    .res(res.source),
    .cfg(cfg.sink)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pix_item_t  pixel_q[$];
  reg_write_t reg_q[$];
  orient_t    orient_q[$];

  int errors = 0;
  int results_seen = 0;
  int pixels_sent = 0;
  int phases_run = 0;
  bit calm = 1'b0;

  // shadow of the block: configuration and per-column accumulators
  logic [7:0]  m_thr;
  logic [14:0] m_fw;
  logic [8:0]  m_bw, m_bh;
  logic [6:0]  m_ba, m_bd;
  logic [16:0] m_lo, m_hi;
  logic [23:0] sum_wr[64], sum_wc[64], sum_br[64], sum_bc[64];
  logic [16:0] cnt_w[64];
  int unsigned pos_line, pos_col, pos_row, blk_col, blk_row;
  bit beyond_cols, beyond_grid;

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  function automatic int unsigned clip(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic longint rnd_angle(input longint t);
    return (t + (longint'(1) << (ROUND_SH - 1))) >>> ROUND_SH;
  endfunction

  function automatic longint orientation(input longint num, input longint den);
    longint x, y, z, xs, ys, t, lim, mx, my, big;
    bit neg;
    z = 0;
    if (den < 0) begin
      den = -den;
      num = -num;
    end
    mx = den;
    neg = num < 0;
    my = neg ? -num : num;
    big = (mx > my) ? mx : my;
    while (big < (longint'(1) << 52)) begin
      mx = mx << 1;
      my = my << 1;
      big = big << 1;
    end
    x = mx;
    y = neg ? -my : my;
    for (int i = 0; i < RUN_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      t = rnd_angle(ATAN_TAB[i]);
      if (y >= 0) begin
        x += ys; y -= xs; z += t;
      end else begin
        x -= ys; y += xs; z -= t;
      end
    end
    lim = rnd_angle(HALF_PI_TAB);
    if (z > lim) z = lim;
    if (z < -lim) z = -lim;
    return z;
  endfunction

  function automatic void apply_reg(input reg_idx_t idx, input logic [16:0] d);
    case (idx)
      REG_THRESHOLD:     m_thr = d[7:0];
      REG_FRAME_WIDTH:   m_fw = d[14:0];
      REG_BLOCK_WIDTH:   m_bw = d[8:0];
      REG_BLOCK_HEIGHT:  m_bh = d[8:0];
      REG_BLOCKS_ACROSS: m_ba = d[6:0];
      REG_BLOCKS_DOWN:   m_bd = d[6:0];
      REG_LOWER_COUNT:   m_lo = d;
      REG_UPPER_COUNT:   m_hi = d;
      default: ;
    endcase
  endfunction

  function automatic void track_pixel(input logic [7:0] p, input logic sof);
    int unsigned fw, bw, bh, ba, bd, c;
    longint nw, nb, tot, cr, cc, ang;
    bit ok;
    orient_t o;
    fw = clip(m_fw, FW_MAX);
    bw = clip(m_bw, SIDE_MAX);
    bh = clip(m_bh, SIDE_MAX);
    ba = clip(m_ba, ACROSS_MAX);
    bd = clip(m_bd, 64);
    if (sof) begin
      pos_line = 0; pos_col = 0; pos_row = 0; blk_col = 0; blk_row = 0;
      beyond_cols = 0; beyond_grid = 0;
    end
    if (!beyond_grid && !beyond_cols && blk_col < ba && blk_row < bd) begin
      c = blk_col & 63;
      if (pos_row == 0 && pos_col == 0) begin
        sum_wr[c] = '0; sum_wc[c] = '0; sum_br[c] = '0; sum_bc[c] = '0; cnt_w[c] = '0;
      end
      if (p > m_thr) begin
        sum_wr[c] += pos_row;
        sum_wc[c] += pos_col;
        cnt_w[c] += 1;
      end else begin
        sum_br[c] += pos_row;
        sum_bc[c] += pos_col;
      end
      if (pos_col + 1 >= bw && pos_row + 1 >= bh) begin
        nw = cnt_w[c];
        tot = longint'(bw) * bh;
        nb = (tot > nw) ? tot - nw : 0;
        cr = longint'(sum_wr[c]) * nb - longint'(sum_br[c]) * nw;
        cc = longint'(sum_wc[c]) * nb - longint'(sum_bc[c]) * nw;
        ok = (cnt_w[c] > m_lo) && (cnt_w[c] < m_hi);
        ang = (ok && cc != 0) ? orientation(cr, cc) : 0;
        o.brow = blk_row[5:0];
        o.bcol = c[5:0];
        o.angle = ang[14:0];
        o.ok = ok;
        o.last = (blk_row + 1 == bd) && (blk_col + 1 == ba);
        orient_q.push_back(o);
      end
    end
    if (pos_line + 1 >= fw) begin
      pos_line = 0; pos_col = 0; blk_col = 0; beyond_cols = 0;
      if (pos_row + 1 >= bh) begin
        pos_row = 0;
        if (blk_row + 1 >= bd) begin
          blk_row = 0;
          beyond_grid = 1;
        end else blk_row = (blk_row + 1) & 63;
      end else pos_row = (pos_row + 1) & 255;
    end else begin
      pos_line = (pos_line + 1) & 16383;
      if (pos_col + 1 >= bw) begin
        pos_col = 0;
        if (blk_col + 1 >= ba) begin
          blk_col = 0;
          beyond_cols = 1;
        end else blk_col = (blk_col + 1) & 63;
      end else pos_col = (pos_col + 1) & 255;
    end
  endfunction

  // pixel driver
  int pix_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      pix.valid <= 1'b0;
    end else if (!pix.valid || pix.ready) begin
      if (pix_gap > 0) begin
        pix_gap <= pix_gap - 1;
        pix.valid <= 1'b0;
      end else if (!calm && $urandom_range(19) == 0) begin
        pix_gap <= $urandom_range(15);
        pix.valid <= 1'b0;
      end else if (pixel_q.size() > 0) begin
        pix_item_t it;
        it = pixel_q.pop_front();
        pix.valid <= 1'b1;
        pix.pixel <= it.pixel;
        pix.start_of_frame <= it.sof;
      end else begin
        pix.valid <= 1'b0;
      end
    end
  end

  // register write driver
  always @(posedge clk) begin
    if (rst) begin
      cfg.valid <= 1'b0;
    end else if (!cfg.valid || cfg.ready) begin
      if (reg_q.size() > 0) begin
        reg_write_t w;
        w = reg_q.pop_front();
        cfg.valid <= 1'b1;
        cfg.index <= w.idx;
        cfg.data <= w.data;
      end else begin
        cfg.valid <= 1'b0;
      end
    end
  end

  // result sink with stall bursts
  int res_stall = 0;
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else if (res_stall > 0) begin
      res_stall <= res_stall - 1;
      res.ready <= 1'b0;
    end else if (!calm && $urandom_range(9) == 0) begin
      res_stall <= $urandom_range(15);
      res.ready <= 1'b0;
    end else begin
      res.ready <= 1'b1;
    end
  end

  // monitor: inputs feed the shadow, results are checked against it
  always @(posedge clk) begin
    if (rst) begin
      m_thr = 8'd128; m_fw = 15'd640; m_bw = 9'd16; m_bh = 9'd16;
      m_ba = 7'd40; m_bd = 7'd30; m_lo = 17'd0; m_hi = 17'd65536;
      pos_line = 0; pos_col = 0; pos_row = 0; blk_col = 0; blk_row = 0;
      beyond_cols = 0; beyond_grid = 0;
    end else begin
      if (cfg.valid && cfg.ready) apply_reg(reg_idx_t'(cfg.index), cfg.data);
      if (pix.valid && pix.ready) track_pixel(pix.pixel, pix.start_of_frame);
      if (res.valid && res.ready) begin
        results_seen++;
        if (orient_q.size() == 0) begin
          report($sformatf("unexpected block result row %0d col %0d",
                           res.block_row, res.block_col));
        end else begin
          orient_t e;
          e = orient_q.pop_front();
          if (res.block_row !== e.brow)
            report($sformatf("block_row %0d, want %0d", res.block_row, e.brow));
          if (res.block_col !== e.bcol)
            report($sformatf("block_col %0d, want %0d", res.block_col, e.bcol));
          if (res.angle !== e.angle)
            report($sformatf("angle %0d, want %0d (block %0d,%0d)",
                             res.angle, $signed(e.angle), e.brow, e.bcol));
          if (res.blend_ok !== e.ok)
            report($sformatf("blend_ok %0b, want %0b", res.blend_ok, e.ok));
          if (res.last_of_frame !== e.last)
            report($sformatf("last_of_frame %0b, want %0b", res.last_of_frame, e.last));
        end
      end
    end
  end

  // watchdog on cycles with no beat anywhere
  int quiet = 0;
  always @(posedge clk) begin
    if (rst || (pix.valid && pix.ready) || (res.valid && res.ready) ||
        (cfg.valid && cfg.ready)) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", quiet);
      $display("block_centroid_orientation_tb: FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic settle();
    while (pixel_q.size() > 0 || pix.valid || orient_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(input logic [16:0] thr, input logic [16:0] fw,
                          input logic [16:0] bw, input logic [16:0] bh,
                          input logic [16:0] ba, input logic [16:0] bd,
                          input logic [16:0] lo, input logic [16:0] hi);
    reg_write_t w;
    settle();
    w.idx = REG_THRESHOLD;     w.data = thr; reg_q.push_back(w);
    w.idx = REG_FRAME_WIDTH;   w.data = fw;  reg_q.push_back(w);
    w.idx = REG_BLOCK_WIDTH;   w.data = bw;  reg_q.push_back(w);
    w.idx = REG_BLOCK_HEIGHT;  w.data = bh;  reg_q.push_back(w);
    w.idx = REG_BLOCKS_ACROSS; w.data = ba;  reg_q.push_back(w);
    w.idx = REG_BLOCKS_DOWN;   w.data = bd;  reg_q.push_back(w);
    w.idx = REG_LOWER_COUNT;   w.data = lo;  reg_q.push_back(w);
    w.idx = REG_UPPER_COUNT;   w.data = hi;  reg_q.push_back(w);
    while (reg_q.size() > 0 || cfg.valid) @(posedge clk);
    phases_run++;
  endtask

  // one frame: random, ramp or flat content, now and then a stray start mark
  task automatic push_frame(input int unsigned npix, input int unsigned fw);
    int unsigned style, dr, dc, base, stray;
    pix_item_t it;
    style = $urandom_range(3);
    dr = $urandom_range(255);
    dc = $urandom_range(255);
    base = $urandom_range(255);
    stray = ($urandom_range(9) == 0) ? $urandom_range(npix - 1) : 0;
    for (int unsigned k = 0; k < npix; k++) begin
      case (style)
        0, 1: it.pixel = $urandom_range(255);
        2:    it.pixel = 8'(base + (k / fw) * dr + (k % fw) * dc);
        default: it.pixel = ($urandom_range(7) == 0) ? 8'($urandom) : 8'(base);
      endcase
      it.sof = (k == 0) || (stray != 0 && k == stray);
      pixel_q.push_back(it);
    end
    pixels_sent += npix;
  endtask

  function automatic int unsigned rows_of(input int unsigned bh, input int unsigned bd);
    return clip(bh, SIDE_MAX) * clip(bd, 64);
  endfunction

  initial begin
    int unsigned bw, bh, ba, bd, fw, tot, lo, hi, thr, frames;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: threshold extremes, 2x2 grid of 2x2 blocks, a mixed frame, then all-255 pixels read as black
    set_regs(0, 4, 2, 2, 2, 2, 0, 65536);
    for (int k = 0; k < 16; k++) begin
      pixel_q.push_back('{pixel: (k % 3 == 0) ? 8'd0 : 8'd255, sof: k == 0});
    end
    pixels_sent += 16;
    set_regs(255, 4, 2, 2, 2, 2, 0, 65536);
    for (int k = 0; k < 8; k++) pixel_q.push_back('{pixel: 8'd255, sof: k == 0});
    pixels_sent += 8;

    // zero registers taken as one, and oversize values limited
    set_regs(100, 0, 0, 0, 0, 0, 0, 2);
    push_frame(3, 1);
    set_regs(127, 1, 511, 256, 1, 1, 0, 131071);
    push_frame(256, 1);
    set_regs(50, 32767, 256, 1, 127, 1, 65536, 65536);
    push_frame(200, 16384);
    set_regs(200, 16384, 256, 1, 64, 1, 10, 200);
    push_frame(200, 16384);
    set_regs(128, 2, 1, 1, 2, 127, 0, 65536);
    push_frame(2 * 64 + 3, 2);

    while (pixels_sent < ITEM_GOAL) begin
      if (pixels_sent > ITEM_GOAL - 250) calm = 1'b1;
      bw = $urandom_range(1, 5);
      bh = $urandom_range(1, 4);
      ba = $urandom_range(1, 5);
      bd = $urandom_range(1, 4);
      case ($urandom_range(5))
        0: fw = ba * bw - $urandom_range(0, bw - 1);
        1: fw = ba * bw + $urandom_range(1, 6);
        default: fw = ba * bw;
      endcase
      tot = bw * bh;
      lo = $urandom_range(0, tot / 3);
      hi = $urandom_range(tot / 2, tot + 1);
      if ($urandom_range(3) == 0) begin
        lo = 0;
        hi = 65536;
      end
      thr = ($urandom_range(7) == 0) ? 8'(255 * $urandom_range(1)) : $urandom_range(255);
      set_regs(17'(thr), 17'(fw), 17'(bw), 17'(bh), 17'(ba), 17'(bd), 17'(lo), 17'(hi));
      frames = $urandom_range(1, 3);
      for (int f = 0; f < frames; f++)
        push_frame(fw * rows_of(bh, bd) + $urandom_range(0, 5) * fw, fw);
    end

    settle();
    $display("covered %0d pixels over %0d register settings", pixels_sent, phases_run);
    $display("%0d block results checked, %0d mismatches", results_seen, errors);
    if (errors == 0) begin
      $display("block_centroid_orientation_tb: PASS");
    end else begin
      $display("block_centroid_orientation_tb: FAIL");
    end
    $finish;
  end

endmodule
